FILE: rtl/core/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer queue.
// ---------------------------------------------------------------------------
package stq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 32;

  localparam int TIME_W     = 48;
  localparam int DELAY_W    = 32;
  localparam int PAYLOAD_W  = 32;
  localparam int TICK_W     = 20;
  localparam int US_PER_MS  = 1000;
  localparam int US_PER_MS_W = 10;
  localparam int PROD_W     = DELAY_W + US_PER_MS_W;
  localparam int KIND_W     = 2;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [TICK_W-1:0] TICK_US_RESET = TICK_W'(1000);

  // register index taken from the byte address
  localparam logic REG_TICK_US = 1'b0;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_SET_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

  typedef struct packed {
    logic insert;
    logic pop;
  } stq_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/sorted_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_timer_queue
// One-shot timers kept in deadline order in a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Usage: a transaction is taken at a clock edge with start high and busy
// low. op_i selects set (add a timer due at now + delay_ms_i*1000 us) or
// tick (advance the microsecond clock by tick_us, then fire due timers).
// Results appear on kind_o/event_tag_o/pending_o/last_o for exactly one cycle
// with result_valid_o high; the receiver cannot stall, so no result waits.
// A set gives one result after multiply, add and insert (after multiply if full);
// the insert is one step in which every cell compares the new deadline
// with its own and the later cells shift down by one.
// A tick gives its first result after the clock is advanced, then one fired
// timer per cycle: each cycle pops the head cell and the chain shifts up.
// busy stays high until the last result is registered, so the next transaction
// can be taken in its cycle.
// tick_us is written over APB at byte address 0, by the user only while idle;
// unenforced. Reset empties the queue, clears the clock, sets tick_us to 1000.
// ---------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int DEPTH    = stq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = stq_pkg::TAG_BITS_DEF,
  localparam int PendW   = $clog2(DEPTH + 1)
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [stq_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire [stq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [stq_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  wire                              start,
  output logic                             busy,
  input  wire                              op_i,
  input  wire [stq_pkg::DELAY_W-1:0]       delay_ms_i,
  input  wire [stq_pkg::PAYLOAD_W-1:0]     payload_i,
  output logic                             result_valid_o,
  output logic [stq_pkg::KIND_W-1:0]       kind_o,
  output logic [stq_pkg::PAYLOAD_W-1:0]    event_tag_o,
  output logic [PendW-1:0]                 pending_o,
  output logic                             last_o
);
  import stq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;
  localparam logic [2:0] S_FIRE = 3'd5;

  localparam logic [TIME_W-1:0] TimeMax = {TIME_W{1'b1}};

  logic [2:0]          state_q, state_d;
  logic [TICK_W-1:0]   tick_q;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [PendW-1:0]    count_q, count_d;
  logic [DELAY_W-1:0]  delay_q;
  logic [TAG_BITS-1:0] new_tag_q;
  logic [PROD_W-1:0]   prod_q;
  logic [TIME_W-1:0]   due_q;
  logic                op_q;

  logic                out_vld_q, out_vld_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [TAG_BITS-1:0] out_tag_q, out_tag_d;
  logic [PendW-1:0]    pend_q, pend_d;
  logic                last_q, last_d;

  stq_ctrl_t           ctrl;
  logic [TIME_W-1:0]   key;
  logic                accept;
  logic                full;
  logic                cfg_wr;
  logic [TIME_W:0]     due_sum;
  logic [TIME_W:0]     tick_sum;

  logic [DEPTH-1:0]    valid_w, le_w, place_w;
  logic [TIME_W-1:0]   dl_w  [DEPTH];
  logic [TAG_BITS-1:0] tag_w [DEPTH];
  logic [DEPTH:0]      le_ext;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign full    = (count_q == PendW'(DEPTH));
  assign key     = (state_q == S_INS) ? due_q : now_q;
  assign le_ext  = {1'b0, le_w};
  assign due_sum  = {1'b0, now_q} + (TIME_W + 1)'(prod_q);
  assign tick_sum = {1'b0, now_q} + (TIME_W + 1)'(tick_q);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TICK_US) ? APB_DATA_W'(tick_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TICK_US_RESET;
    end else if (cfg_wr && (paddr[2] == REG_TICK_US)) begin
      tick_q <= pwdata[TICK_W-1:0];
    end
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                prev_place, prev_valid, next_valid;
    logic [TIME_W-1:0]   prev_dl, next_dl;
    logic [TAG_BITS-1:0] prev_tag, next_tag;

    if (i == 0) begin : g_head
      assign prev_place = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_dl    = due_q;
      assign prev_tag   = new_tag_q;
    end else begin : g_body
      assign prev_place = place_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_dl    = dl_w[i-1];
      assign prev_tag   = tag_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_dl    = due_q;
      assign next_tag   = new_tag_q;
    end else begin : g_mid
      assign next_valid = valid_w[i+1];
      assign next_dl    = dl_w[i+1];
      assign next_tag   = tag_w[i+1];
    end

    stq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key),
      .new_dl_i     (due_q),
      .new_tag_i    (new_tag_q),
      .prev_place_i (prev_place),
      .prev_valid_i (prev_valid),
      .prev_dl_i    (prev_dl),
      .prev_tag_i   (prev_tag),
      .next_valid_i (next_valid),
      .next_dl_i    (next_dl),
      .next_tag_i   (next_tag),
      .valid_o      (valid_w[i]),
      .dl_o         (dl_w[i]),
      .tag_o        (tag_w[i]),
      .le_o         (le_w[i]),
      .place_o      (place_w[i])
    );
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    count_d   = count_q;
    ctrl      = '0;
    out_vld_d = 1'b0;
    kind_d    = kind_q;
    out_tag_d = out_tag_q;
    pend_d    = pend_q;
    last_d    = last_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = (op_i == OP_TICK) ? S_TICK : S_MUL;
        end
      end
      S_MUL: begin
        if (full) begin
          state_d   = S_IDLE;
          out_vld_d = 1'b1;
          kind_d    = KIND_SET_FULL;
          out_tag_d = '0;
          pend_d    = count_q;
          last_d    = 1'b1;
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        state_d = S_INS;
      end
      S_INS: begin
        ctrl.insert = 1'b1;
        count_d     = count_q + 1'b1;
        state_d     = S_IDLE;
        out_vld_d   = 1'b1;
        kind_d      = KIND_SET_OK;
        out_tag_d   = '0;
        pend_d      = count_q + 1'b1;
        last_d      = 1'b1;
      end
      S_TICK: begin
        now_d   = tick_sum[TIME_W] ? TimeMax : tick_sum[TIME_W-1:0];
        state_d = S_FIRE;
      end
      S_FIRE: begin
        out_vld_d = 1'b1;
        if (le_ext[0]) begin
          ctrl.pop  = 1'b1;
          count_d   = count_q - 1'b1;
          kind_d    = KIND_FIRED;
          out_tag_d = tag_w[0];
          pend_d    = count_q - 1'b1;
          last_d    = !le_ext[1];
          if (!le_ext[1]) begin
            state_d = S_IDLE;
          end
        end else begin
          // only reached when a tick enters the fire state with nothing due
          kind_d    = KIND_NONE;
          out_tag_d = '0;
          pend_d    = count_q;
          last_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      now_q     <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_i;
      delay_q   <= delay_ms_i;
      new_tag_q <= TAG_BITS'(payload_i);
    end
    prod_q    <= PROD_W'(delay_q) * PROD_W'(US_PER_MS);
    if (state_q == S_ADD) begin
      due_q <= due_sum[TIME_W] ? TimeMax : due_sum[TIME_W-1:0];
    end
    kind_q    <= kind_d;
    out_tag_q <= out_tag_d;
    pend_q    <= pend_d;
    last_q    <= last_d;
  end

  assign result_valid_o = out_vld_q;
  assign kind_o         = kind_q;
  assign event_tag_o    = PAYLOAD_W'(out_tag_q);
  assign pending_o      = pend_q;
  assign last_o         = last_q;

  // the occupied cells always form the front of the chain and match the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(count_q))
    else $error("cell occupancy does not match queue count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PendW'(DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy)
    else $error("last result shown while sequencer still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> (op_q == OP_SET) && !full)
    else $error("insert without an accepted set transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIRE) && le_ext[0] |=> result_valid_o && (kind_o == KIND_FIRED))
    else $error("due head popped without a fired result");

endmodule
`default_nettype wire

FILE: rtl/core/stq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stq_cell
// One slot of the sorted timer chain: holds a deadline and tag, compares
// against the shared key and shifts with its neighbors on insert or pop.
// ---------------------------------------------------------------------------
module stq_cell #(
  parameter int TAG_BITS = stq_pkg::TAG_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  stq_pkg::stq_ctrl_t           ctrl_i,
  input  wire [stq_pkg::TIME_W-1:0]    key_i,
  input  wire [stq_pkg::TIME_W-1:0]    new_dl_i,
  input  wire [TAG_BITS-1:0]           new_tag_i,
  input  wire                          prev_place_i,
  input  wire                          prev_valid_i,
  input  wire [stq_pkg::TIME_W-1:0]    prev_dl_i,
  input  wire [TAG_BITS-1:0]           prev_tag_i,
  input  wire                          next_valid_i,
  input  wire [stq_pkg::TIME_W-1:0]    next_dl_i,
  input  wire [TAG_BITS-1:0]           next_tag_i,
  output logic                         valid_o,
  output logic [stq_pkg::TIME_W-1:0]   dl_o,
  output logic [TAG_BITS-1:0]          tag_o,
  output logic                         le_o,
  output logic                         place_o
);
  import stq_pkg::*;

  logic                valid_q, valid_d;
  logic [TIME_W-1:0]   dl_q, dl_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  assign le_o    = valid_q && (dl_q <= key_i);
  // new entry belongs at or before this slot
  assign place_o = !le_o;

  always_comb begin
    valid_d = valid_q;
    dl_d    = dl_q;
    tag_d   = tag_q;
    if (ctrl_i.insert) begin
      if (place_o && !prev_place_i) begin
        valid_d = 1'b1;
        dl_d    = new_dl_i;
        tag_d   = new_tag_i;
      end else if (place_o) begin
        valid_d = prev_valid_i;
        dl_d    = prev_dl_i;
        tag_d   = prev_tag_i;
      end
    end else if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      dl_d    = next_dl_i;
      tag_d   = next_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q  <= dl_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign dl_o    = dl_q;
  assign tag_o   = tag_q;

endmodule
`default_nettype wire
